[rtl/core/sorted_point_list_scan_top_assert.svh]
// Assertion helpers used by the top level of the point list block.
`ifndef SORTED_POINT_LIST_SCAN_TOP_ASSERT_SVH
`define SORTED_POINT_LIST_SCAN_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SPLS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define SPLS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/spls_pkg.sv]
package spls_pkg;

    // Table geometry.
    localparam int MAX_POINTS = 64;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths.
    localparam int PCT_W    = 7;
    localparam int DAC_W    = 8;
    localparam int STATUS_W = 2;
    localparam int PROD_W   = PCT_W + DAC_W;

    // Percent saturation limit.
    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

    // Division by 100 as a reciprocal multiply: floor(p * 5243 / 2^19) is exact
    // for every product up to 100 * 255.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam int WIDE_W      = PROD_W + RECIP_W;

    // Input item kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SCAN   = 1'b1;

    // Configuration register indexes.
    localparam logic REG_X_FULL_SCALE = 1'b0;
    localparam logic REG_Y_FULL_SCALE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_POINT    = 2'd0,
        STAT_ACCEPTED = 2'd1,
        STAT_DROPPED  = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    // Control states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // Operation broadcast to every cell of the chain, all cells acting in the same cycle.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ROTATE = 2'd2
    } chain_op_t;

    // One stored point.
    typedef struct packed {
        logic             valid;
        logic [PCT_W-1:0] x;
        logic [PCT_W-1:0] y;
    } point_t;

    // Command broadcast along the chain.
    typedef struct packed {
        chain_op_t        op;
        logic [PCT_W-1:0] x;
        logic [PCT_W-1:0] y;
    } chain_ctrl_t;

    // One result entering the scaling pipeline.
    typedef struct packed {
        logic             valid;
        logic [PCT_W-1:0] x;
        logic [PCT_W-1:0] y;
        status_t          status;
        logic             last;
    } issue_t;

endpackage

[rtl/core/spls_cell.sv]
module spls_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spls_pkg::chain_ctrl_t ctrl,
    input  spls_pkg::point_t     prev_pt,
    input  logic                 prev_gt,
    input  spls_pkg::point_t     next_pt,
    input  spls_pkg::point_t     head_pt,
    output spls_pkg::point_t     cell_pt,
    output logic                 cell_gt
);
    import spls_pkg::*;

    logic             valid_reg, valid_next;
    logic [PCT_W-1:0] x_reg, x_next;
    logic [PCT_W-1:0] y_reg, y_next;

    assign cell_pt = '{valid: valid_reg, x: x_reg, y: y_reg};

    // This cell holds a point that must move behind the new one.
    assign cell_gt = valid_reg && (x_reg > ctrl.x);

    // Next contents: shift right on insert, shift left with wrap on rotate.
    always_comb begin
        valid_next = valid_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        case (ctrl.op)
            OP_INSERT: begin
                if (prev_gt) begin
                    valid_next = 1'b1;
                    x_next     = prev_pt.x;
                    y_next     = prev_pt.y;
                end else if (prev_pt.valid && (!valid_reg || cell_gt)) begin
                    valid_next = 1'b1;
                    x_next     = ctrl.x;
                    y_next     = ctrl.y;
                end
            end
            OP_ROTATE: begin
                if (next_pt.valid) begin
                    x_next = next_pt.x;
                    y_next = next_pt.y;
                end else if (valid_reg) begin
                    // Last stored point takes the head that leaves the front.
                    x_next = head_pt.x;
                    y_next = head_pt.y;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

endmodule

[rtl/core/spls_chain.sv]
module spls_chain (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  spls_pkg::chain_ctrl_t ctrl,
    output spls_pkg::point_t      head_pt
);
    import spls_pkg::*;

    point_t cell_pt [MAX_POINTS];
    logic   cell_gt [MAX_POINTS];
    point_t prev_pt [MAX_POINTS];
    logic   prev_gt [MAX_POINTS];
    point_t next_pt [MAX_POINTS];

    assign head_pt = cell_pt[0];

    // Neighbor wiring; the front sees an always-valid, never-greater point
    // before it, and the back sees an empty slot after it.
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        if (i == 0) begin : g_front
            assign prev_pt[i] = '{valid: 1'b1, x: '0, y: '0};
            assign prev_gt[i] = 1'b0;
        end else begin : g_inner
            assign prev_pt[i] = cell_pt[i-1];
            assign prev_gt[i] = cell_gt[i-1];
        end

        if (i == MAX_POINTS - 1) begin : g_back
            assign next_pt[i] = '{valid: 1'b0, x: '0, y: '0};
        end else begin : g_body
            assign next_pt[i] = cell_pt[i+1];
        end

        spls_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .prev_pt (prev_pt[i]),
            .prev_gt (prev_gt[i]),
            .next_pt (next_pt[i]),
            .head_pt (cell_pt[0]),
            .cell_pt (cell_pt[i]),
            .cell_gt (cell_gt[i])
        );
    end

endmodule

[rtl/core/spls_scaler.sv]
module spls_scaler (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  spls_pkg::issue_t             issue,
    input  logic [spls_pkg::DAC_W-1:0]   x_full_scale,
    input  logic [spls_pkg::DAC_W-1:0]   y_full_scale,
    output logic                         advance,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: dac_x [7:0], dac_y [15:8]
    output logic [2*spls_pkg::DAC_W-1:0] m_tdata,
    // m_tuser: status [1:0]
    output logic [spls_pkg::STATUS_W-1:0] m_tuser,
    output logic                         m_tlast
);
    import spls_pkg::*;

    // Product stage.
    logic              a_valid_reg, a_valid_next;
    logic [PROD_W-1:0] a_px_reg, a_px_next;
    logic [PROD_W-1:0] a_py_reg, a_py_next;
    status_t           a_status_reg;
    logic              a_last_reg;

    // Output register.
    logic              b_valid_reg, b_valid_next;
    logic [DAC_W-1:0]  b_dx_reg, b_dx_next;
    logic [DAC_W-1:0]  b_dy_reg, b_dy_next;
    status_t           b_status_reg;
    logic              b_last_reg;

    logic [WIDE_W-1:0] wide_x;
    logic [WIDE_W-1:0] wide_y;

    // The whole pipeline moves when the output slot is free or being taken.
    assign advance = !b_valid_reg || m_tready;

    // Percent times full scale.
    always_comb begin
        a_valid_next = issue.valid;
        a_px_next    = PROD_W'(issue.x) * PROD_W'(x_full_scale);
        a_py_next    = PROD_W'(issue.y) * PROD_W'(y_full_scale);
    end

    // Divide by 100 through the reciprocal.
    always_comb begin
        wide_x       = WIDE_W'(a_px_reg) * WIDE_W'(RECIP_100);
        wide_y       = WIDE_W'(a_py_reg) * WIDE_W'(RECIP_100);
        b_dx_next    = wide_x[RECIP_SHIFT +: DAC_W];
        b_dy_next    = wide_y[RECIP_SHIFT +: DAC_W];
        b_valid_next = a_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_px_reg     <= a_px_next;
            a_py_reg     <= a_py_next;
            a_status_reg <= issue.status;
            a_last_reg   <= issue.last;
            b_dx_reg     <= b_dx_next;
            b_dy_reg     <= b_dy_next;
            b_status_reg <= a_status_reg;
            b_last_reg   <= a_last_reg;
        end
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {b_dy_reg, b_dx_reg};
    assign m_tuser  = b_status_reg;
    assign m_tlast  = b_last_reg;

endmodule

[rtl/core/sorted_point_list_scan_top.sv]
// Sorted point list. An insert transfer on the slave side stores one point
// (percent coordinates, saturated to 100) after every stored point with a
// smaller or equal x, and answers with one result: accepted, or dropped when
// all 64 slots are taken. It is stored without a search, since every cell of the
// shift chain decides in parallel whether to keep, take its neighbor or take
// the new point. A scan transfer streams every stored point in x order, one
// per cycle while the master side does not stall, scaled to DAC codes as
// floor(percent * full_scale / 100), with tlast on the final point; an empty
// table gives one result with status empty. After a scan transfer s_tready
// stays low while the chain rotates back into place. Results pass through a
// product stage and an output register, and master-side backpressure stalls
// the whole result path, the chain rotation and the slave side with it.
`include "sorted_point_list_scan_top_assert.svh"

module sorted_point_list_scan_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: point_x [6:0], point_y [13:7], zero [15:14]
    input  logic [15:0]                   s_tdata,
    // s_tuser: kind [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: dac_x [7:0], dac_y [15:8]
    output logic [2*spls_pkg::DAC_W-1:0]  m_tdata,
    // m_tuser: status [1:0]
    output logic [spls_pkg::STATUS_W-1:0] m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [spls_pkg::DAC_W-1:0]    cfg_wdata
);
    import spls_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [DAC_W-1:0] x_fs_reg;
    logic [DAC_W-1:0] y_fs_reg;

    logic             advance;
    logic             s_fire;
    logic             is_full;
    logic             is_empty;
    logic [PCT_W-1:0] in_x;
    logic [PCT_W-1:0] in_y;
    logic [PCT_W-1:0] sat_x;
    logic [PCT_W-1:0] sat_y;
    chain_ctrl_t      ctrl;
    issue_t           issue;
    point_t           head_pt;

    assign in_x     = s_tdata[PCT_W-1:0];
    assign in_y     = s_tdata[2*PCT_W-1:PCT_W];
    assign sat_x    = (in_x > PCT_MAX) ? PCT_MAX : in_x;
    assign sat_y    = (in_y > PCT_MAX) ? PCT_MAX : in_y;
    assign is_full  = (count_reg == CNT_W'(MAX_POINTS));
    assign is_empty = (count_reg == '0);
    assign s_fire   = s_tvalid && s_tready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_fs_reg <= DAC_W'(166);
            y_fs_reg <= DAC_W'(128);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_X_FULL_SCALE: x_fs_reg <= cfg_wdata;
                REG_Y_FULL_SCALE: y_fs_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_tuser == KIND_SCAN) && !is_empty) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (advance && (remain_reg == CNT_W'(1))) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake, chain command, result issue and counters.
    always_comb begin
        s_tready    = 1'b0;
        ctrl        = '{op: OP_HOLD, x: sat_x, y: sat_y};
        issue       = '{valid: 1'b0, x: '0, y: '0, status: STAT_POINT, last: 1'b1};
        count_next  = count_reg;
        remain_next = remain_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = advance;
                if (s_fire) begin
                    if (s_tuser == KIND_INSERT) begin
                        issue.valid = 1'b1;
                        if (is_full) begin
                            issue.status = STAT_DROPPED;
                        end else begin
                            issue.status = STAT_ACCEPTED;
                            ctrl.op      = OP_INSERT;
                            count_next   = count_reg + CNT_W'(1);
                        end
                    end else if (is_empty) begin
                        issue.valid  = 1'b1;
                        issue.status = STAT_EMPTY;
                    end else begin
                        remain_next = count_reg;
                    end
                end
            end
            ST_SCAN: begin
                if (advance) begin
                    ctrl.op     = OP_ROTATE;
                    issue.valid = 1'b1;
                    issue.x     = head_pt.x;
                    issue.y     = head_pt.y;
                    issue.last  = (remain_reg == CNT_W'(1));
                    remain_next = remain_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

    spls_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .head_pt (head_pt)
    );

    spls_scaler u_scaler (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .issue        (issue),
        .x_full_scale (x_fs_reg),
        .y_full_scale (y_fs_reg),
        .advance      (advance),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    // A scan only runs over a non-empty table, never past the stored points.
    `SPLS_ASSERT_NOW(a_scan_nonempty, aclk, aresetn, state_reg == ST_SCAN, !is_empty && (remain_reg != '0))
    `SPLS_ASSERT_NOW(a_remain_bound, aclk, aresetn, state_reg == ST_SCAN, remain_reg <= count_reg)
    `SPLS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_POINTS))
    `SPLS_ASSERT_NEXT(a_drop_keeps_count, aclk, aresetn, s_fire && (s_tuser == KIND_INSERT) && is_full, $stable(count_reg))

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import spls_pkg::*;

    // One item offered on the slave side.
    typedef struct packed {
        logic             kind;
        logic [PCT_W-1:0] x;
        logic [PCT_W-1:0] y;
    } item_t;

    // One result as it should leave the master side.
    typedef struct packed {
        logic [DAC_W-1:0] dac_x;
        logic [DAC_W-1:0] dac_y;
        status_t          status;
        logic             last;
    } result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [2*DAC_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_addr  = REG_X_FULL_SCALE;
    logic [DAC_W-1:0]      cfg_wdata = '0;

    // Shadow copy of the point table and the scale registers.
    logic [PCT_W-1:0] shadow_x [MAX_POINTS];
    logic [PCT_W-1:0] shadow_y [MAX_POINTS];
    int               shadow_count = 0;
    logic [DAC_W-1:0] x_scale = DAC_W'(166);
    logic [DAC_W-1:0] y_scale = DAC_W'(128);

    item_t   pending_items[$];
    result_t expected_results[$];
    item_t   offered_item;
    result_t want;
    int      sent_count     = 0;
    int      rx_count       = 0;
    int      mismatch_count = 0;
    int      hold_left      = 0;
    bit      hold_done      = 1'b0;

    sorted_point_list_scan_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Scale a saturated percent value to a DAC code, rounding down.
    function automatic logic [DAC_W-1:0] to_dac(input logic [PCT_W-1:0] pct,
                                                input logic [DAC_W-1:0] full);
        int unsigned prod;
        prod = int'(pct) * int'(full);
        return DAC_W'(prod / 100);
    endfunction

    // Work out every result caused by one accepted item and queue them.
    task automatic predict_point_list(input item_t it);
        int               pos;
        int               i;
        logic [PCT_W-1:0] px;
        logic [PCT_W-1:0] py;
        result_t          r;
        r.dac_x = '0;
        r.dac_y = '0;
        r.last  = 1'b1;
        if (it.kind == KIND_INSERT) begin
            px = (it.x > PCT_MAX) ? PCT_MAX : it.x;
            py = (it.y > PCT_MAX) ? PCT_MAX : it.y;
            if (shadow_count >= MAX_POINTS) begin
                r.status = STAT_DROPPED;
            end else begin
                // New point goes after every stored point with x not above it.
                pos = 0;
                while (pos < shadow_count && shadow_x[pos] <= px)
                    pos++;
                for (i = shadow_count; i > pos; i--) begin
                    shadow_x[i] = shadow_x[i-1];
                    shadow_y[i] = shadow_y[i-1];
                end
                shadow_x[pos] = px;
                shadow_y[pos] = py;
                shadow_count++;
                r.status = STAT_ACCEPTED;
            end
            expected_results.push_back(r);
        end else if (shadow_count == 0) begin
            r.status = STAT_EMPTY;
            expected_results.push_back(r);
        end else begin
            for (i = 0; i < shadow_count; i++) begin
                r.dac_x  = to_dac(shadow_x[i], x_scale);
                r.dac_y  = to_dac(shadow_y[i], y_scale);
                r.status = STAT_POINT;
                r.last   = (i == shadow_count - 1);
                expected_results.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatch_count++;
        $display("mismatch at result %0d: %s is %0d, should be %0d",
                 rx_count, what, got, exp_val);
    endtask

    task automatic add_item(input logic kind, input int x, input int y);
        item_t it;
        it.kind = kind;
        it.x    = PCT_W'(x);
        it.y    = PCT_W'(y);
        pending_items.push_back(it);
    endtask

    // Stimulus waits until every queued item has gone and every result has come.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_scales(input int xs, input int ys);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_X_FULL_SCALE;
        cfg_wdata <= DAC_W'(xs);
        x_scale = DAC_W'(xs);
        @(posedge aclk);
        cfg_addr  <= REG_Y_FULL_SCALE;
        cfg_wdata <= DAC_W'(ys);
        y_scale = DAC_W'(ys);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Slave-side driver: offers the next pending item, holds it until the transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_point_list(offered_item);
                sent_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 &&
                    !((sent_count < 140 || sent_count >= 180) && $urandom_range(99) < 8)) begin
                    offered_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, offered_item.y, offered_item.x};
                    s_tuser  <= offered_item.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Master-side monitor: checks each transfer and drives backpressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("status of a result nobody waits for", m_tuser, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[DAC_W-1:0] !== want.dac_x)
                        report_mismatch("dac_x", m_tdata[DAC_W-1:0], want.dac_x);
                    if (m_tdata[2*DAC_W-1:DAC_W] !== want.dac_y)
                        report_mismatch("dac_y", m_tdata[2*DAC_W-1:DAC_W], want.dac_y);
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
            end
            // One long hold-off lets the result path back up into the input.
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && rx_count >= 150) begin
                hold_done = 1'b1;
                hold_left = 300;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !((rx_count < 800 || rx_count >= 1600) && $urandom_range(99) < 8);
            end
        end
    end

    // Stimulus: directed cases, then random phases under random scales.
    initial begin : stimulus
        logic kind_v;
        int   x_v;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset scales: empty scan, saturation, head insert, ties, bit patterns.
        add_item(KIND_SCAN, 127, 127);
        add_item(KIND_INSERT, 127, 127);
        add_item(KIND_INSERT, 0, 0);
        add_item(KIND_INSERT, 100, 101);
        add_item(KIND_INSERT, 101, 100);
        add_item(KIND_INSERT, 50, 1);
        add_item(KIND_INSERT, 50, 2);
        add_item(KIND_INSERT, 64, 64);
        add_item(KIND_INSERT, 42, 85);
        add_item(KIND_SCAN, 85, 42);
        wait_drained();

        write_scales(255, 0);
        add_item(KIND_SCAN, 0, 0);
        add_item(KIND_INSERT, 1, 126);
        add_item(KIND_SCAN, 1, 1);
        wait_drained();

        write_scales(0, 255);
        add_item(KIND_SCAN, 0, 0);
        wait_drained();

        write_scales(255, 255);
        add_item(KIND_SCAN, 0, 0);
        wait_drained();

        // Random phases; a third of the x values come from a set that forces ties.
        repeat (2) begin
            write_scales($urandom_range(255), $urandom_range(255));
            repeat (98) begin
                kind_v = ($urandom_range(99) < 22) ? KIND_SCAN : KIND_INSERT;
                case ($urandom_range(11))
                    0:       x_v = 0;
                    1:       x_v = 50;
                    2:       x_v = 100;
                    3:       x_v = 127;
                    default: x_v = $urandom_range(127);
                endcase
                add_item(kind_v, x_v, $urandom_range(127));
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/spls_pkg.sv
rtl/core/spls_cell.sv
rtl/core/spls_chain.sv
rtl/core/spls_scaler.sv
rtl/core/sorted_point_list_scan_top.sv
tb/sv/tb.sv
